>>> src/fat_record_name_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// fat_record_name_decoder_unit_defines.svh
// assertion macros for the directory entry decoder
// ----------------------------------------------------------------------------
`ifndef FAT_RECORD_NAME_DECODER_UNIT_DEFINES_SVH
`define FAT_RECORD_NAME_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

// condition that must hold at every clock edge out of reset
`define FRND_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("fat record name decoder: assertion failed");

// implication checked in the same cycle
`define FRND_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fat record name decoder: assertion failed");

`else

`define FRND_ASSERT(lbl, clk, rstn, prop)
`define FRND_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> src/frnd_pkg.sv
// ----------------------------------------------------------------------------
// frnd_pkg
// shared types and constants of the directory entry decoder
// ----------------------------------------------------------------------------
`default_nettype none

package frnd_pkg;

    // result kinds on the output channel
    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_RECORD = 2'd1,
        KIND_ERROR  = 2'd2
    } result_kind_t;

    // directory entry constants
    localparam logic [7:0] ATTR_LFN       = 8'h0F;
    localparam logic [7:0] MARK_DELETED   = 8'hE5;
    localparam int         SEQ_LAST_BIT   = 6;     // bit 0x40 of the sequence byte
    localparam int         ATTR_DIR_BIT   = 4;     // bit 0x10 of the attribute
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam int         SECTOR_SHIFT   = 9;     // 512-byte sectors
    localparam int         LFN_CHARS      = 13;
    localparam int         MAX_CHARS      = 14;
    localparam logic [7:0] LFN_CHARS_MULT = 8'd13;

    // name buffer length, every slot stays below it
    localparam int NAME_BUFFER_BYTES = 200;

    // byte offsets of the long-name characters within an entry
    localparam logic [LFN_CHARS-1:0][4:0] LFN_OFFSETS = {
        5'd30, 5'd28, 5'd24, 5'd22, 5'd20, 5'd18, 5'd16,
        5'd14, 5'd9,  5'd7,  5'd5,  5'd3,  5'd1
    };

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // one classified item, as the back end plays it out
    typedef struct packed {
        logic                       has_record;
        logic                       is_error;
        logic [3:0]                 char_count;
        logic [7:0]                 char_base;
        logic [MAX_CHARS-1:0][7:0]  chars;
        logic [31:0]                first_location;
        logic [31:0]                record_location;
        logic [31:0]                first_cluster;
        logic [31:0]                size_bytes;
        logic [23:0]                sector_count;
        logic                       is_directory;
    } job_t;

    // queue status seen by front and back
    typedef struct packed {
        logic can_push;
        logic head_valid;
    } queue_status_t;

endpackage

`default_nettype wire

>>> src/frnd_front.sv
// ----------------------------------------------------------------------------
// frnd_front
// accepts entries, tracks the chain state and builds one job per item
// ----------------------------------------------------------------------------
`default_nettype none

module frnd_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_chain_start,
    input  wire logic [31:0]             s_entry_location,
    input  wire logic [63:0]             s_entry_word0,
    input  wire logic [63:0]             s_entry_word1,
    input  wire logic [63:0]             s_entry_word2,
    input  wire logic [63:0]             s_entry_word3,
    input  wire frnd_pkg::queue_status_t q_status,
    output logic                         push,
    output frnd_pkg::job_t               push_job
);
    import frnd_pkg::*;

    logic        name_enable_reg, name_enable_next;
    logic [31:0] chain_first_reg, chain_first_next;
    logic        name_head_reg, name_head_next;

    logic [31:0][7:0] eb;
    logic             accept;
    logic             is_deleted, is_long;
    logic [7:0]       seq_minus;
    logic [3:0]       lfn_off;
    logic [7:0]       lfn_base;
    logic [31:0]      first_loc_eff;
    logic             head_eff;
    logic [31:0]      size_w;
    logic [23:0]      sectors;

    logic [3:0]       sn_len;
    logic [1:0]       ext_len;
    logic             ext_on;
    logic [3:0]       sn_count;
    logic [2:0][7:0]  ext_bytes;
    logic [MAX_CHARS-1:0][7:0] sn_chars;
    logic [3:0]       rel;
    logic [1:0]       ext_idx;

    // entry bytes, byte 0 lowest
    assign eb = {s_entry_word3, s_entry_word2, s_entry_word1, s_entry_word0};
    assign ext_bytes = eb[10:8];

    assign s_ready = q_status.can_push;
    assign accept  = s_valid && s_ready;

    // classification
    assign is_deleted = (eb[0] == MARK_DELETED);
    assign is_long    = !is_deleted && (eb[11] == ATTR_LFN);

    // long-name slot base
    assign seq_minus = eb[0] - 8'd1;
    assign lfn_off   = (seq_minus[3:0] == 4'hF) ? 4'hE : seq_minus[3:0];
    assign lfn_base  = {4'b0, lfn_off} * LFN_CHARS_MULT;

    // chain state as seen by this item
    assign first_loc_eff = s_chain_start ? s_entry_location : chain_first_reg;
    assign head_eff      = s_chain_start ? 1'b0 : name_head_reg;

    // record fields
    assign size_w  = {eb[31], eb[30], eb[29], eb[28]};
    assign sectors = {1'b0, size_w[31:SECTOR_SHIFT]} + {23'b0, |size_w[SECTOR_SHIFT-1:0]};

    // trimmed short name length
    always_comb begin
        sn_len = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (eb[i] != CHAR_SPACE) begin
                sn_len = 4'(i + 1);
            end
        end
    end

    // extension length and presence
    assign ext_on  = (eb[8] != CHAR_SPACE);
    assign ext_len = (eb[10] != CHAR_SPACE) ? 2'd3 : ((eb[9] != CHAR_SPACE) ? 2'd2 : 2'd1);
    assign sn_count = sn_len + (ext_on ? ({2'b0, ext_len} + 4'd1) : 4'd0) + 4'd1;

    // packed 8.3 name, terminator included
    always_comb begin
        sn_chars = '0;
        rel      = 4'd0;
        ext_idx  = 2'd0;
        for (int p = 0; p < LFN_CHARS; p++) begin
            rel     = 4'(p) - sn_len;
            ext_idx = 2'(rel - 4'd1);
            if (4'(p) < sn_len) begin
                sn_chars[p] = eb[p];
            end else if (ext_on && rel == 4'd0) begin
                sn_chars[p] = CHAR_DOT;
            end else if (ext_on && rel >= 4'd1 && rel <= {2'b0, ext_len}) begin
                sn_chars[p] = ext_bytes[ext_idx];
            end
        end
    end

    // job for the queue
    always_comb begin
        push_job = '0;
        priority if (is_deleted) begin
            push_job.is_error = 1'b1;
        end else if (is_long) begin
            for (int i = 0; i < LFN_CHARS; i++) begin
                push_job.chars[i] = eb[LFN_OFFSETS[i]];
            end
            push_job.char_count = eb[0][SEQ_LAST_BIT] ? 4'(MAX_CHARS) : 4'(LFN_CHARS);
            push_job.char_base  = lfn_base;
        end else begin
            push_job.has_record      = 1'b1;
            push_job.first_location  = first_loc_eff;
            push_job.record_location = s_entry_location;
            push_job.first_cluster   = {eb[21], eb[20], eb[27], eb[26]};
            push_job.size_bytes      = size_w;
            push_job.sector_count    = sectors;
            push_job.is_directory    = eb[11][ATTR_DIR_BIT];
            if (name_enable_reg && !head_eff) begin
                push_job.chars      = sn_chars;
                push_job.char_count = sn_count;
            end
        end
    end

    // a long entry with names off gives no result and needs no job
    assign push = accept && !(is_long && !name_enable_reg);

    // next chain state
    always_comb begin
        chain_first_next = chain_first_reg;
        name_head_next   = name_head_reg;
        name_enable_next = cfg_we ? cfg_wdata : name_enable_reg;
        if (accept) begin
            chain_first_next = first_loc_eff;
            name_head_next   = head_eff;
            if (is_long && name_enable_reg && lfn_off == 4'd0) begin
                name_head_next = (eb[1] != 8'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_enable_reg <= 1'b1;
            chain_first_reg <= '0;
            name_head_reg   <= 1'b0;
        end else begin
            name_enable_reg <= name_enable_next;
            chain_first_reg <= chain_first_next;
            name_head_reg   <= name_head_next;
        end
    end

endmodule

`default_nettype wire

>>> src/frnd_queue.sv
// ----------------------------------------------------------------------------
// frnd_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
`default_nettype none

module frnd_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire frnd_pkg::job_t   push_job,
    input  wire logic             pop,
    output frnd_pkg::job_t        head_job,
    output frnd_pkg::queue_status_t q_status
);
    import frnd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_status.can_push   = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_status.head_valid = (count_reg != '0);
    assign head_job            = mem[rd_ptr_reg];

    assign do_push = push && q_status.can_push;
    assign do_pop  = pop && q_status.head_valid;

    // pointer and fill update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> src/frnd_back.sv
// ----------------------------------------------------------------------------
// frnd_back
// plays out the head job as results, one per cycle unless stalled, via an output register
// ----------------------------------------------------------------------------
`default_nettype none

module frnd_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire frnd_pkg::job_t          head_job,
    input  wire frnd_pkg::queue_status_t q_status,
    output logic                         pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [1:0]                   m_result_kind,
    output logic [7:0]                   m_char_position,
    output logic [7:0]                   m_char_value,
    output logic [31:0]                  m_first_location,
    output logic [31:0]                  m_record_location,
    output logic [31:0]                  m_first_cluster,
    output logic [31:0]                  m_size_bytes,
    output logic [23:0]                  m_sector_count,
    output logic                         m_is_directory,
    output logic                         m_last
);
    import frnd_pkg::*;

    logic [3:0]   step_reg, step_next;
    logic         valid_reg, valid_next;
    logic [3:0]   total;
    logic [3:0]   char_idx;
    logic         is_last, advance;
    result_kind_t kind;

    logic [1:0]   kind_reg;
    logic [7:0]   pos_reg, val_reg;
    logic [31:0]  first_loc_reg, rec_loc_reg, cluster_reg, size_reg;
    logic [23:0]  sectors_reg;
    logic         dir_reg, last_reg;

    // result count of the head job
    assign total    = {3'b0, head_job.has_record} + {3'b0, head_job.is_error}
                      + head_job.char_count;
    assign is_last  = (step_reg == total - 4'd1);
    assign char_idx = step_reg - {3'b0, head_job.has_record};
    assign advance  = q_status.head_valid && (!valid_reg || m_ready);
    assign pop      = advance && is_last;

    // kind of the current step
    always_comb begin
        priority if (head_job.is_error) begin
            kind = KIND_ERROR;
        end else if (head_job.has_record && step_reg == 4'd0) begin
            kind = KIND_RECORD;
        end else begin
            kind = KIND_CHAR;
        end
    end

    // step counter and output valid
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
            step_next  = is_last ? 4'd0 : step_reg + 4'd1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // result payload, unused fields zero
    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg      <= kind;
            last_reg      <= is_last;
            pos_reg       <= '0;
            val_reg       <= '0;
            first_loc_reg <= '0;
            rec_loc_reg   <= '0;
            cluster_reg   <= '0;
            size_reg      <= '0;
            sectors_reg   <= '0;
            dir_reg       <= 1'b0;
            unique case (kind)
                KIND_RECORD: begin
                    first_loc_reg <= head_job.first_location;
                    rec_loc_reg   <= head_job.record_location;
                    cluster_reg   <= head_job.first_cluster;
                    size_reg      <= head_job.size_bytes;
                    sectors_reg   <= head_job.sector_count;
                    dir_reg       <= head_job.is_directory;
                end
                KIND_CHAR: begin
                    pos_reg <= head_job.char_base + {4'b0, char_idx};
                    val_reg <= head_job.chars[char_idx];
                end
                default: begin
                end
            endcase
        end
    end

    assign m_valid           = valid_reg;
    assign m_result_kind     = kind_reg;
    assign m_char_position   = pos_reg;
    assign m_char_value      = val_reg;
    assign m_first_location  = first_loc_reg;
    assign m_record_location = rec_loc_reg;
    assign m_first_cluster   = cluster_reg;
    assign m_size_bytes      = size_reg;
    assign m_sector_count    = sectors_reg;
    assign m_is_directory    = dir_reg;
    assign m_last            = last_reg;

endmodule

`default_nettype wire

>>> src/fat_record_name_decoder_unit.sv
// An accepted entry is pushed as a job into the queue, and its results are registered
// at the output, one result per cycle while the output is not stalled. A long-name entry
// gives 13 or 14 results, a short entry 1 to 14, a deleted entry 1, and a long entry while
// names are off none. A two-job queue lets entries be accepted while results drain.
// Reset: aresetn low (synchronous) empties the queue and output, clears the chain state
// and sets name_enable to 1.
// ----------------------------------------------------------------------------
// fat_record_name_decoder_unit
// directory entry chain decoder: long-name characters, record and short name
// ----------------------------------------------------------------------------
`default_nettype none

`include "fat_record_name_decoder_unit_defines.svh"

module fat_record_name_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_chain_start,
    input  wire logic [31:0] s_entry_location,
    input  wire logic [63:0] s_entry_word0,
    input  wire logic [63:0] s_entry_word1,
    input  wire logic [63:0] s_entry_word2,
    input  wire logic [63:0] s_entry_word3,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_result_kind,
    output logic [7:0]       m_char_position,
    output logic [7:0]       m_char_value,
    output logic [31:0]      m_first_location,
    output logic [31:0]      m_record_location,
    output logic [31:0]      m_first_cluster,
    output logic [31:0]      m_size_bytes,
    output logic [23:0]      m_sector_count,
    output logic             m_is_directory,
    output logic             m_last
);
    import frnd_pkg::*;

    queue_status_t q_status;
    job_t          push_job, head_job;
    logic          push, pop;

    // front end: classify and track chain state
    frnd_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_chain_start    (s_chain_start),
        .s_entry_location (s_entry_location),
        .s_entry_word0    (s_entry_word0),
        .s_entry_word1    (s_entry_word1),
        .s_entry_word2    (s_entry_word2),
        .s_entry_word3    (s_entry_word3),
        .q_status         (q_status),
        .push             (push),
        .push_job         (push_job)
    );

    // job queue
    frnd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // back end: result sequencer
    frnd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head_job          (head_job),
        .q_status          (q_status),
        .pop               (pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_char_position   (m_char_position),
        .m_char_value      (m_char_value),
        .m_first_location  (m_first_location),
        .m_record_location (m_record_location),
        .m_first_cluster   (m_first_cluster),
        .m_size_bytes      (m_size_bytes),
        .m_sector_count    (m_sector_count),
        .m_is_directory    (m_is_directory),
        .m_last            (m_last)
    );

    // checks
    `FRND_ASSERT_IMP(a_char_in_buffer, aclk, aresetn,
        m_valid && m_result_kind == KIND_CHAR,
        int'(m_char_position) < NAME_BUFFER_BYTES)
    `FRND_ASSERT_IMP(a_error_is_last, aclk, aresetn,
        m_valid && m_result_kind == KIND_ERROR, m_last)
    `FRND_ASSERT_IMP(a_record_no_char, aclk, aresetn,
        m_valid && m_result_kind == KIND_RECORD,
        m_char_position == 8'd0 && m_char_value == 8'd0)
    `FRND_ASSERT(a_no_pop_on_stall, aclk, aresetn, !(m_valid && !m_ready && pop))

endmodule

`default_nettype wire

>>> verif/tb_fat_record_name_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_fat_record_name_decoder_unit
// Drives directory entry chains into the decoder through random valid and
// ready gaps. A behavioural decoder built from the entry bytes works out the
// character, record and error items that each entry should give. Every
// item that leaves the block is compared field by field against the oldest
// of those. Directed cases come first, then random chains with noise.
// ----------------------------------------------------------------------------
module tb_fat_record_name_decoder_unit;
    import frnd_pkg::*;

    localparam int IDLE_PCT      = 28;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RESULTS_MAX   = 14;
    localparam int LFN_CHAR_AT [13] = '{1, 3, 5, 7, 9, 14, 16, 18, 20, 22, 24, 28, 30};
    localparam logic [7:0] ATTR_PLAIN = 8'h20;
    localparam logic [7:0] ATTR_DIR   = 8'h10;

    // one directory entry as it enters the block, byte k at raw[8k +: 8]
    typedef struct packed {
        logic         chain_start;
        logic [31:0]  location;
        logic [255:0] raw;
    } dir_entry_t;

    // one decoded output item
    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   slot;
        logic [7:0]   ch;
        logic [31:0]  first_loc;
        logic [31:0]  rec_loc;
        logic [31:0]  cluster;
        logic [31:0]  size_b;
        logic [23:0]  sectors;
        logic         is_dir;
        logic         last;
    } dir_result_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_chain_start;
    logic [31:0] s_entry_location;
    logic [63:0] s_entry_word0;
    logic [63:0] s_entry_word1;
    logic [63:0] s_entry_word2;
    logic [63:0] s_entry_word3;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_result_kind;
    logic [7:0]  m_char_position;
    logic [7:0]  m_char_value;
    logic [31:0] m_first_location;
    logic [31:0] m_record_location;
    logic [31:0] m_first_cluster;
    logic [31:0] m_size_bytes;
    logic [23:0] m_sector_count;
    logic        m_is_directory;
    logic        m_last;

    // decoder state mirrored by the testbench
    logic        names_on;
    logic [31:0] chain_origin;
    logic        slot0_named;

    dir_result_t pending_results[$];
    bit          steady;
    int          fail_count;
    int          entries_sent;
    int          chains_sent;
    int          results_checked;

    fat_record_name_decoder_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_chain_start     (s_chain_start),
        .s_entry_location  (s_entry_location),
        .s_entry_word0     (s_entry_word0),
        .s_entry_word1     (s_entry_word1),
        .s_entry_word2     (s_entry_word2),
        .s_entry_word3     (s_entry_word3),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_char_position   (m_char_position),
        .m_char_value      (m_char_value),
        .m_first_location  (m_first_location),
        .m_record_location (m_record_location),
        .m_first_cluster   (m_first_cluster),
        .m_size_bytes      (m_size_bytes),
        .m_sector_count    (m_sector_count),
        .m_is_directory    (m_is_directory),
        .m_last            (m_last)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // entry helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] entry_byte(input dir_entry_t e, input int k);
        return e.raw[k*8 +: 8];
    endfunction

    function automatic dir_entry_t with_byte(input dir_entry_t e, input int k,
                                             input logic [7:0] v);
        e.raw[k*8 +: 8] = v;
        return e;
    endfunction

    function automatic dir_entry_t random_entry();
        dir_entry_t e;
        e.chain_start = 1'($urandom_range(0, 1));
        e.location    = $urandom;
        for (int i = 0; i < 8; i++) e.raw[i*32 +: 32] = $urandom;
        return e;
    endfunction

    function automatic logic [103:0] random_text();
        logic [103:0] t;
        for (int i = 0; i < 13; i++) t[i*8 +: 8] = 8'($urandom_range(0, 255));
        return t;
    endfunction

    // long-name fragment; text holds 13 characters, first one in the top byte
    function automatic dir_entry_t lfn_entry(input logic cs, input logic [7:0] seq,
                                             input logic [103:0] text);
        dir_entry_t e;
        e = random_entry();
        e.chain_start = cs;
        e = with_byte(e, 0, seq);
        e = with_byte(e, 11, ATTR_LFN);
        for (int i = 0; i < 13; i++) e = with_byte(e, LFN_CHAR_AT[i], text[(12-i)*8 +: 8]);
        return e;
    endfunction

    // short entry; name is the 11-byte 8.3 field, first byte in the top byte
    function automatic dir_entry_t short_entry(input logic cs, input logic [87:0] name,
                                               input logic [7:0] attr,
                                               input logic [31:0] cluster,
                                               input logic [31:0] size_b);
        dir_entry_t e;
        e = random_entry();
        e.chain_start = cs;
        for (int i = 0; i < 11; i++) e = with_byte(e, i, name[(10-i)*8 +: 8]);
        e = with_byte(e, 11, attr);
        e = with_byte(e, 20, cluster[23:16]);
        e = with_byte(e, 21, cluster[31:24]);
        e = with_byte(e, 26, cluster[7:0]);
        e = with_byte(e, 27, cluster[15:8]);
        for (int i = 0; i < 4; i++) e = with_byte(e, 28 + i, size_b[i*8 +: 8]);
        return e;
    endfunction

    function automatic dir_entry_t random_short(input logic cs);
        logic [87:0] name;
        logic [7:0]  attr;
        logic [31:0] size_b;
        for (int i = 0; i < 11; i++) begin
            if ($urandom_range(0, 9) == 0) name[i*8 +: 8] = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < 30) name[i*8 +: 8] = CHAR_SPACE;
            else name[i*8 +: 8] = 8'($urandom_range(8'h21, 8'h7E));
        end
        // keep the first byte clear of the deleted marker
        if (name[87:80] == MARK_DELETED) name[87:80] = 8'h5F;
        attr = 8'($urandom_range(0, 255));
        if (attr == ATTR_LFN) attr = ATTR_DIR;
        size_b = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2048));
        return short_entry(cs, name, attr, $urandom, size_b);
    endfunction

    function automatic dir_entry_t deleted_entry(input logic cs);
        dir_entry_t e;
        e = random_entry();
        e.chain_start = cs;
        return with_byte(e, 0, MARK_DELETED);
    endfunction

    // ------------------------------------------------------------------
    // behavioural decoder
    // ------------------------------------------------------------------
    function automatic void emit_char(ref dir_result_t rows[$], input int unsigned slot,
                                      input logic [7:0] value);
        dir_result_t c;
        if (slot < NAME_BUFFER_BYTES && rows.size() < RESULTS_MAX) begin
            c      = '0;
            c.kind = KIND_CHAR;
            c.slot = slot[7:0];
            c.ch   = value;
            rows.push_back(c);
        end
    endfunction

    function automatic void decode_entry(input dir_entry_t e);
        dir_result_t rows[$];
        dir_result_t rec;
        logic [7:0]  seq;
        logic [7:0]  attr;
        logic [7:0]  v;
        logic [3:0]  grp;
        int unsigned base;
        int unsigned blen;
        int unsigned elen;
        int unsigned pos;
        seq  = entry_byte(e, 0);
        attr = entry_byte(e, 11);
        if (e.chain_start) begin
            chain_origin = e.location;
            slot0_named  = 1'b0;
        end

        // deleted marker wins over everything else
        if (seq == MARK_DELETED) begin
            rec      = '0;
            rec.kind = KIND_ERROR;
            rec.last = 1'b1;
            pending_results.push_back(rec);
            return;
        end

        if (attr == ATTR_LFN) begin
            if (!names_on) return;
            grp = seq[3:0] - 4'd1;
            if (grp == 4'hF) grp = 4'hE;
            base = 13 * grp;
            for (int i = 0; i < 13; i++) begin
                v = entry_byte(e, LFN_CHAR_AT[i]);
                if (base + i == 0) slot0_named = (v != 8'h00);
                emit_char(rows, base + i, v);
            end
            if (seq[SEQ_LAST_BIT]) emit_char(rows, base + 13, 8'h00);
        end else begin
            rec           = '0;
            rec.kind      = KIND_RECORD;
            rec.first_loc = chain_origin;
            rec.rec_loc   = e.location;
            rec.cluster   = {entry_byte(e, 21), entry_byte(e, 20),
                             entry_byte(e, 27), entry_byte(e, 26)};
            rec.size_b    = {entry_byte(e, 31), entry_byte(e, 30),
                             entry_byte(e, 29), entry_byte(e, 28)};
            rec.sectors   = {1'b0, rec.size_b[31:SECTOR_SHIFT]} + 24'(|rec.size_b[8:0]);
            rec.is_dir    = attr[ATTR_DIR_BIT];
            rows.push_back(rec);

            // 8.3 name only when no long name filled slot 0
            if (names_on && !slot0_named) begin
                blen = 8;
                while (blen > 0 && entry_byte(e, blen - 1) == CHAR_SPACE) blen--;
                for (int i = 0; i < blen; i++) emit_char(rows, i, entry_byte(e, i));
                pos = blen;
                if (entry_byte(e, 8) != CHAR_SPACE) begin
                    elen = 3;
                    while (elen > 1 && entry_byte(e, 8 + elen - 1) == CHAR_SPACE) elen--;
                    emit_char(rows, pos, CHAR_DOT);
                    pos++;
                    for (int i = 0; i < elen; i++) begin
                        emit_char(rows, pos, entry_byte(e, 8 + i));
                        pos++;
                    end
                end
                emit_char(rows, pos, 8'h00);
            end
        end

        if (rows.size() > 0) begin
            rows[rows.size() - 1].last = 1'b1;
            foreach (rows[i]) pending_results.push_back(rows[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    task automatic send_entry(input dir_entry_t e);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_chain_start    <= e.chain_start;
        s_entry_location <= e.location;
        s_entry_word0    <= e.raw[63:0];
        s_entry_word1    <= e.raw[127:64];
        s_entry_word2    <= e.raw[191:128];
        s_entry_word3    <= e.raw[255:192];
        s_valid          <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        decode_entry(e);
        entries_sent++;
        @(negedge aclk);
    endtask

    // drop valid, wait for every pending item, then let the block go quiet
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_name_enable(input logic on);
        settle_idle();
        cfg_wdata <= on;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        names_on   = on;
    endtask

    // output back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic int field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin : result_check
        dir_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("item with no decode pending: kind %0d slot %0d",
                       m_result_kind, m_char_position);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                fail_count += field_mismatch("result_kind", want.kind, m_result_kind);
                fail_count += field_mismatch("char_position", want.slot, m_char_position);
                fail_count += field_mismatch("char_value", want.ch, m_char_value);
                fail_count += field_mismatch("first_location", want.first_loc,
                                             m_first_location);
                fail_count += field_mismatch("record_location", want.rec_loc,
                                             m_record_location);
                fail_count += field_mismatch("first_cluster", want.cluster, m_first_cluster);
                fail_count += field_mismatch("size_bytes", want.size_b, m_size_bytes);
                fail_count += field_mismatch("sector_count", want.sectors, m_sector_count);
                fail_count += field_mismatch("is_directory", want.is_dir, m_is_directory);
                fail_count += field_mismatch("last", want.last, m_last);
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    initial begin : watchdog
        int stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stuck = 0;
            else stuck++;
        end
        $display("tb_fat_record_name_decoder_unit NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // fragment slots, terminators, sequence clamping and slot 0 tracking
    task automatic test_long_names();
        dir_entry_t e;
        e = lfn_entry(1'b1, 8'h42, "abcdefghijklm");
        e.location = '0;
        send_entry(e);
        send_entry(lfn_entry(1'b0, 8'h01, "Long file nam"));
        e = short_entry(1'b0, "LONGFI~1TXT", ATTR_PLAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        e.location = 32'hFFFF_FFFF;
        send_entry(e);
        // empty first character, so the 8.3 name follows the record
        send_entry(lfn_entry(1'b1, 8'h41, {8'h00, {12{8'hFF}}}));
        send_entry(short_entry(1'b0, "README  TXT", 8'h01, 32'h0, 32'd513));
        // sequence zero and fifteen both land in the top group
        send_entry(lfn_entry(1'b1, 8'h00, "zero sequence"));
        send_entry(lfn_entry(1'b0, 8'h4F, "fifteen, last"));
        send_entry(lfn_entry(1'b0, 8'h50, "sixteen, last"));
        send_entry(short_entry(1'b0, "A       B  ", ATTR_DIR, 32'h0001_0002, 32'h0));
        chains_sent += 3;
    endtask

    // 8.3 trimming and size rounding
    task automatic test_short_names();
        send_entry(short_entry(1'b1, "           ", 8'h00, 32'h0, 32'd1));
        send_entry(short_entry(1'b1, "ABCDEFGHIJK", 8'h3F, 32'h8000_0001, 32'd512));
        send_entry(short_entry(1'b1, "FILE     XY", 8'h04, 32'h1234_5678, 32'h1FF));
        send_entry(short_entry(1'b1, 88'h0, 8'h00, 32'h0, 32'h200));
        chains_sent += 4;
    endtask

    // deleted marker, also on a long-name entry, still opens a chain
    task automatic test_deleted_entries();
        send_entry(deleted_entry(1'b1));
        send_entry(with_byte(deleted_entry(1'b0), 11, ATTR_LFN));
        send_entry(short_entry(1'b0, "AFTERDELTMP", ATTR_PLAIN, $urandom, $urandom));
    endtask

    // names off: long entries vanish, records stay bare
    task automatic test_names_off();
        set_name_enable(1'b0);
        send_entry(lfn_entry(1'b1, 8'h41, "hidden name!!"));
        send_entry(short_entry(1'b0, "HIDDEN  TXT", ATTR_PLAIN, $urandom, $urandom));
        send_entry(deleted_entry(1'b0));
        set_name_enable(1'b1);
        send_entry(short_entry(1'b0, "NAMES   ON ", ATTR_PLAIN, $urandom, $urandom));
    endtask

    // mostly well-formed chains with random content, the rest noise
    task automatic test_random_chains(input int target);
        dir_entry_t   e;
        logic [103:0] text;
        logic [7:0]   seq;
        int           sent;
        int           frags;
        int           pick;
        sent = 0;
        while (sent < target) begin
            steady = (sent >= target / 3) && (sent < target / 2);
            pick   = $urandom_range(0, 99);
            if (pick < 70) begin
                frags = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 15)
                                                     : $urandom_range(1, 4);
                for (int k = frags; k >= 1; k--) begin
                    text = random_text();
                    if (k == 1 && $urandom_range(0, 3) == 0) text[103:96] = 8'h00;
                    seq = k[7:0];
                    if (k == frags) seq[SEQ_LAST_BIT] = 1'b1;
                    e = lfn_entry(k == frags && $urandom_range(0, 9) != 0, seq, text);
                    send_entry(e);
                    sent++;
                end
                send_entry(random_short(1'b0));
                sent++;
                chains_sent++;
            end else if (pick < 80) begin
                send_entry(deleted_entry(1'($urandom_range(0, 1))));
                sent++;
            end else if (pick < 90) begin
                send_entry(random_short(1'($urandom_range(0, 1))));
                sent++;
            end else begin
                e = random_entry();
                if ($urandom_range(0, 1)) e = with_byte(e, 11, ATTR_LFN);
                send_entry(e);
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn          = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 1'b0;
        s_valid          = 1'b0;
        s_chain_start    = 1'b0;
        s_entry_location = '0;
        s_entry_word0    = '0;
        s_entry_word1    = '0;
        s_entry_word2    = '0;
        s_entry_word3    = '0;
        steady           = 1'b0;
        fail_count       = 0;
        entries_sent     = 0;
        chains_sent      = 0;
        results_checked  = 0;
        names_on         = 1'b1;
        chain_origin     = '0;
        slot0_named      = 1'b0;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_name_enable(1'b1);
        test_long_names();
        test_short_names();
        test_deleted_entries();
        test_names_off();

        test_random_chains(68);
        set_name_enable(1'b0);
        test_random_chains(12);
        set_name_enable(1'b1);
        test_random_chains(18);

        settle_idle();
        $display("decoded %0d entries in %0d chains, both name settings", entries_sent,
                 chains_sent);
        $display("%0d output items compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_fat_record_name_decoder_unit OK");
        end else begin
            $display("tb_fat_record_name_decoder_unit NOT OK");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/frnd_pkg.sv
src/frnd_front.sv
src/frnd_queue.sv
src/frnd_back.sv
src/fat_record_name_decoder_unit.sv
verif/tb_fat_record_name_decoder_unit.sv
